// ===== hw/rtl/rpi_pkg.sv =====
package rpi_pkg;

  // Fixed-point format of coordinates and coefficients
  localparam int COORD_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 4;

  // Exact widths of the intermediate terms
  localparam int DIR_W  = COORD_W + 1;
  localparam int NUM_W  = ((2 * COORD_W > COORD_W + FRAC_BITS) ?
                           2 * COORD_W : COORD_W + FRAC_BITS) + 3;
  localparam int DEN_W  = 2 * COORD_W + 3;
  localparam int PROD_W = NUM_W + DIR_W;
  // Quotient bits kept; anything larger saturates regardless of the centre
  localparam int QUO_W  = COORD_W + 2;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_PLANE_A  = 3'd3,
    REG_PLANE_B  = 3'd4,
    REG_PLANE_C  = 3'd5,
    REG_PLANE_D  = 3'd6
  } cfg_reg_t;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } in_item_t;

  typedef struct packed {
    coord_t hit_x;
    coord_t hit_y;
    coord_t hit_z;
    logic   parallel;
    logic   saturated;
  } out_item_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    coord_t plane_a;
    coord_t plane_b;
    coord_t plane_c;
    coord_t plane_d;
  } cfg_t;

  // Work handed from the front to the divider: denominator and num*dir per axis
  typedef struct packed {
    logic [DEN_W-1:0]  den;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic [PROD_W-1:0] prod_z;
  } job_t;

endpackage

// ===== hw/rtl/rpi_front.sv =====
module rpi_front (
  input  logic              clk,
  input  logic              rst_n,
  input  rpi_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  rpi_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output rpi_pkg::job_t     q_job
);

  localparam int W   = rpi_pkg::COORD_W;
  localparam int F   = rpi_pkg::FRAC_BITS;
  localparam int DW  = rpi_pkg::DIR_W;
  localparam int NW  = rpi_pkg::NUM_W;
  localparam int EW  = rpi_pkg::DEN_W;
  localparam int PW  = rpi_pkg::PROD_W;
  localparam int NL  = NW / 2;
  localparam int NH  = NW - NL;

  logic              en;
  logic [4:0]        v_r;
  logic signed [W-1:0] ctr [3];
  logic signed [W-1:0] nrm [3];
  logic signed [W-1:0] pt  [3];
  logic signed [W-1:0] pd;

  logic signed [DW-1:0]    dir1_r [3];
  logic signed [DW-1:0]    dir2_r [3];
  logic signed [DW-1:0]    dir3_r [3];
  logic signed [2*W:0]     dn_r   [3];
  logic signed [2*W-1:0]   nm_r   [3];
  logic signed [W-1:0]     d2_r;
  logic signed [EW-1:0]    den3_r, den4_r, den5_r;
  logic signed [NW-1:0]    num3_r;
  logic signed [NL+DW:0]   pl_r   [3];
  logic signed [NH+DW-1:0] ph_r   [3];
  logic signed [PW-1:0]    prod_r [3];
  logic signed [NW-1:0]    dsh;

  assign ctr[0] = cfg.center_x;
  assign ctr[1] = cfg.center_y;
  assign ctr[2] = cfg.center_z;
  assign nrm[0] = cfg.plane_a;
  assign nrm[1] = cfg.plane_b;
  assign nrm[2] = cfg.plane_c;
  assign pd     = cfg.plane_d;
  assign pt[0]  = in_data.point_x;
  assign pt[1]  = in_data.point_y;
  assign pt[2]  = in_data.point_z;

  // The whole front moves together; it holds only when its last stage cannot transfer
  assign en       = !(v_r[4] && q_full);
  assign in_stall = !en;
  assign q_push   = v_r[4] && !q_full;

  // d scaled to the product format
  assign dsh = {{(NW-W-F){d2_r[W-1]}}, d2_r, {F{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // direction P - O
        dir1_r[i] <= {pt[i][W-1], pt[i]} - {ctr[i][W-1], ctr[i]};
        // normal products for den and num
        dn_r[i]   <= nrm[i] * dir1_r[i];
        nm_r[i]   <= nrm[i] * ctr[i];
        dir2_r[i] <= dir1_r[i];
        dir3_r[i] <= dir2_r[i];
        // num * dir in two partial products
        pl_r[i]   <= $signed({1'b0, num3_r[NL-1:0]}) * dir3_r[i];
        ph_r[i]   <= $signed(num3_r[NW-1:NL]) * dir3_r[i];
        prod_r[i] <= $signed({ph_r[i], {NL{1'b0}}}) + pl_r[i];
      end
      d2_r   <= pd;
      den3_r <= dn_r[0] + dn_r[1] + dn_r[2];
      num3_r <= -(dsh + nm_r[0] + nm_r[1] + nm_r[2]);
      den4_r <= den3_r;
      den5_r <= den4_r;
    end
  end

  assign q_job.den    = den5_r;
  assign q_job.prod_x = prod_r[0];
  assign q_job.prod_y = prod_r[1];
  assign q_job.prod_z = prod_r[2];

endmodule

// ===== hw/rtl/rpi_queue.sv =====
module rpi_queue #(
  parameter int DEPTH = rpi_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpi_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output rpi_pkg::job_t dout,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rpi_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rpi_back.sv =====
module rpi_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rpi_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  rpi_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rpi_pkg::out_item_t out_data
);

  localparam int W   = rpi_pkg::COORD_W;
  localparam int EW  = rpi_pkg::DEN_W;
  localparam int PW  = rpi_pkg::PROD_W;
  localparam int K   = rpi_pkg::QUO_W;
  localparam int CMW = ((PW > EW + K) ? PW : EW + K) + 1;
  localparam int SW  = K + 3;

  localparam logic [SW-1:0] SMAX_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [SW-1:0] SMIN_S = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic en;

  // pipeline: stage 0 is set-up, stages 1..K each resolve one quotient bit
  logic [K:0]    v_r;
  logic [K:0]    par_r;
  logic [EW-1:0] dab_r [K+1];
  logic [PW-1:0] rem_r [3][K+1];
  logic [K-1:0]  q_r   [3][K+1];
  logic          neg_r [3][K+1];
  logic          ovf_r [3][K+1];

  logic [PW-1:0] rem_nxt [3][K+1];
  logic [K-1:0]  q_nxt   [3][K+1];

  logic signed [PW-1:0] prod [3];
  logic signed [EW-1:0] den;
  logic [EW-1:0]        dab0;
  logic [PW-1:0]        nab0 [3];
  logic                 neg0 [3];
  logic                 ovf0 [3];
  logic signed [W-1:0]  ctr  [3];

  logic          out_valid_r;
  rpi_pkg::out_item_t out_data_r, out_nxt;

  assign en        = !(out_valid_r && out_stall);
  assign q_pop     = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign prod[0] = q_job.prod_x;
  assign prod[1] = q_job.prod_y;
  assign prod[2] = q_job.prod_z;
  assign den     = q_job.den;
  assign ctr[0]  = cfg.center_x;
  assign ctr[1]  = cfg.center_y;
  assign ctr[2]  = cfg.center_z;

  // set-up: magnitudes, quotient sign and out-of-range detection
  always_comb begin
    dab0 = den[EW-1] ? EW'(-den) : EW'(den);
    for (int l = 0; l < 3; l++) begin
      nab0[l] = prod[l][PW-1] ? PW'(-prod[l]) : PW'(prod[l]);
      neg0[l] = prod[l][PW-1] ^ den[EW-1];
      ovf0[l] = (CMW'(nab0[l]) >= (CMW'(dab0) << K));
    end
  end

  // restoring division steps, one independent step per stage
  always_comb begin
    logic [CMW-1:0] sh;
    for (int l = 0; l < 3; l++) begin
      rem_nxt[l][0] = '0;
      q_nxt[l][0]   = '0;
      for (int s = 1; s <= K; s++) begin
        sh = CMW'(dab_r[s-1]) << (K - s);
        rem_nxt[l][s] = rem_r[l][s-1];
        q_nxt[l][s]   = q_r[l][s-1];
        if (CMW'(rem_r[l][s-1]) >= sh) begin
          rem_nxt[l][s]       = rem_r[l][s-1] - sh[PW-1:0];
          q_nxt[l][s][K - s]  = 1'b1;
        end
      end
    end
  end

  // rounding, centre offset, saturation and the parallel-ray output
  always_comb begin
    logic          rnd;
    logic [K:0]    qr;
    logic [SW-1:0] sv, sum;
    logic [W-1:0]  hit [3];
    logic          sat;
    sat = 1'b0;
    for (int l = 0; l < 3; l++) begin
      rnd = (CMW'({rem_r[l][K], 1'b0}) >= CMW'(dab_r[K]));
      qr  = {1'b0, q_r[l][K]} + (K+1)'(rnd);
      sv  = neg_r[l][K] ? -SW'(qr) : SW'(qr);
      sum = {{(SW-W){ctr[l][W-1]}}, ctr[l]} + sv;
      if (ovf_r[l][K]) begin
        hit[l] = neg_r[l][K] ? SMIN_S[W-1:0] : SMAX_S[W-1:0];
        sat    = 1'b1;
      end else if ($signed(sum) > $signed(SMAX_S)) begin
        hit[l] = SMAX_S[W-1:0];
        sat    = 1'b1;
      end else if ($signed(sum) < $signed(SMIN_S)) begin
        hit[l] = SMIN_S[W-1:0];
        sat    = 1'b1;
      end else begin
        hit[l] = sum[W-1:0];
      end
    end
    if (par_r[K]) begin
      out_nxt.hit_x     = '0;
      out_nxt.hit_y     = '0;
      out_nxt.hit_z     = '0;
      out_nxt.parallel  = 1'b1;
      out_nxt.saturated = 1'b0;
    end else begin
      out_nxt.hit_x     = hit[0];
      out_nxt.hit_y     = hit[1];
      out_nxt.hit_z     = hit[2];
      out_nxt.parallel  = 1'b0;
      out_nxt.saturated = sat;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[K-1:0], q_pop};
      out_valid_r <= v_r[K];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      dab_r[0] <= dab0;
      par_r[0] <= (den == '0);
      for (int l = 0; l < 3; l++) begin
        rem_r[l][0] <= nab0[l];
        q_r[l][0]   <= '0;
        neg_r[l][0] <= neg0[l];
        ovf_r[l][0] <= ovf0[l];
      end
      for (int s = 1; s <= K; s++) begin
        dab_r[s] <= dab_r[s-1];
        par_r[s] <= par_r[s-1];
        for (int l = 0; l < 3; l++) begin
          rem_r[l][s] <= rem_nxt[l][s];
          q_r[l][s]   <= q_nxt[l][s];
          neg_r[l][s] <= neg_r[l][s-1];
          ovf_r[l][s] <= ovf_r[l][s-1];
        end
      end
      out_data_r <= out_nxt;
    end
  end

endmodule

// ===== hw/rtl/ray_plane_intersection.sv =====
// Ray / plane intersection, signed fixed point, one result per point.
// Most of the pipeline is the divider, which resolves one quotient bit per stage.
// Throughput: one point per cycle, sustained while the result side takes results.
// Reset (rst_n low, synchronous): pipeline and queue empty, registers at defaults.
module ray_plane_intersection #(
  parameter int QUEUE_DEPTH = rpi_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rpi_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rpi_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [rpi_pkg::COORD_W-1:0]  cfg_data
);

  localparam int W = rpi_pkg::COORD_W;

  rpi_pkg::cfg_t cfg_r;
  rpi_pkg::job_t push_job, pop_job;
  logic          q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x <= '0;
      cfg_r.center_y <= '0;
      cfg_r.center_z <= '0;
      cfg_r.plane_a  <= '0;
      cfg_r.plane_b  <= '0;
      cfg_r.plane_c  <= W'(1) << rpi_pkg::FRAC_BITS;
      cfg_r.plane_d  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpi_pkg::REG_CENTER_X: cfg_r.center_x <= cfg_data;
        rpi_pkg::REG_CENTER_Y: cfg_r.center_y <= cfg_data;
        rpi_pkg::REG_CENTER_Z: cfg_r.center_z <= cfg_data;
        rpi_pkg::REG_PLANE_A:  cfg_r.plane_a  <= cfg_data;
        rpi_pkg::REG_PLANE_B:  cfg_r.plane_b  <= cfg_data;
        rpi_pkg::REG_PLANE_C:  cfg_r.plane_c  <= cfg_data;
        rpi_pkg::REG_PLANE_D:  cfg_r.plane_d  <= cfg_data;
        default: ;
      endcase
    end
  end

  rpi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  rpi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (pop_job),
    .empty (q_empty)
  );

  rpi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/ray_plane_intersection_tb.sv =====
`timescale 1ns / 1ps

module ray_plane_intersection_tb;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    rpi_pkg::in_item_t  pt;
    bit                 typed;
    rpi_pkg::out_item_t want;
  } stim_row_t;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 60;
  localparam int PHASES      = 8;
  localparam int PER_PHASE   = 190;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  rpi_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  rpi_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  rpi_pkg::coord_t    cfg_data;

  rpi_pkg::cfg_t      geom;
  rpi_pkg::out_item_t hits_pending[$];
  stim_row_t          rows[$];
  int        errors;
  int        n_points;
  int        n_hits;
  int        n_parallel;
  int        n_sat;
  int        idle_count;
  bit        quiet;
  bit        hold_req;

  ray_plane_intersection dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic wide_t sx(rpi_pkg::coord_t v);
    logic signed [31:0] s;
    s = v;
    return s;
  endfunction

  // Hit point of the ray from the centre through p, rounded and clamped
  function automatic rpi_pkg::out_item_t hit_of(rpi_pkg::in_item_t p);
    wide_t              org[3];
    wide_t              nrm[3];
    wide_t              dir[3];
    wide_t              num, den, n, d, q, r, h;
    wide_t              smax, smin;
    rpi_pkg::coord_t    res[3];
    bit                 neg;
    rpi_pkg::out_item_t o;
    org[0] = sx(geom.center_x); org[1] = sx(geom.center_y); org[2] = sx(geom.center_z);
    nrm[0] = sx(geom.plane_a);  nrm[1] = sx(geom.plane_b);  nrm[2] = sx(geom.plane_c);
    dir[0] = sx(p.point_x) - org[0];
    dir[1] = sx(p.point_y) - org[1];
    dir[2] = sx(p.point_z) - org[2];
    smax = sx(32'h7fff_ffff);
    smin = sx(32'h8000_0000);
    num = sx(geom.plane_d) * (wide_t'(1) <<< rpi_pkg::FRAC_BITS);
    den = 0;
    for (int i = 0; i < 3; i++) begin
      num = num + nrm[i] * org[i];
      den = den + nrm[i] * dir[i];
    end
    num = -num;
    o = '0;
    if (den == 0) begin
      o.parallel = 1'b1;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      n = num * dir[i];
      d = den;
      neg = (n < 0) != (d < 0);
      if (n < 0) n = -n;
      if (d < 0) d = -d;
      q = n / d;
      r = n - q * d;
      // round to nearest, ties away from zero
      if (2 * r >= d) q = q + 1;
      if (neg) q = -q;
      h = org[i] + q;
      if (h > smax) begin
        h = smax;
        o.saturated = 1'b1;
      end else if (h < smin) begin
        h = smin;
        o.saturated = 1'b1;
      end
      res[i] = h[31:0];
    end
    o.hit_x = res[0];
    o.hit_y = res[1];
    o.hit_z = res[2];
    return o;
  endfunction

  function automatic rpi_pkg::coord_t rand_coord();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return rpi_pkg::coord_t'($signed($urandom_range(0, 32'h0010_0000))
                                        - 32'sh0008_0000);
      3:       return rpi_pkg::coord_t'($signed($urandom_range(0, 32'h0400_0000))
                                        - 32'sh0200_0000);
      4: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      default: return rpi_pkg::coord_t'($signed($urandom_range(0, 16)) - 8)
                      <<< rpi_pkg::FRAC_BITS;
    endcase
  endfunction

  // Register write; the block is idle whenever this is called
  task automatic write_reg(rpi_pkg::cfg_reg_t idx, rpi_pkg::coord_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rpi_pkg::REG_CENTER_X: geom.center_x = val;
      rpi_pkg::REG_CENTER_Y: geom.center_y = val;
      rpi_pkg::REG_CENTER_Z: geom.center_z = val;
      rpi_pkg::REG_PLANE_A:  geom.plane_a  = val;
      rpi_pkg::REG_PLANE_B:  geom.plane_b  = val;
      rpi_pkg::REG_PLANE_C:  geom.plane_c  = val;
      rpi_pkg::REG_PLANE_D:  geom.plane_d  = val;
      default: ;
    endcase
  endtask

  // Stop offering points and wait for every outstanding result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_all(rpi_pkg::coord_t cx, rpi_pkg::coord_t cy, rpi_pkg::coord_t cz,
                           rpi_pkg::coord_t a, rpi_pkg::coord_t b, rpi_pkg::coord_t c,
                           rpi_pkg::coord_t d);
    wait_idle();
    write_reg(rpi_pkg::REG_CENTER_X, cx);
    write_reg(rpi_pkg::REG_CENTER_Y, cy);
    write_reg(rpi_pkg::REG_CENTER_Z, cz);
    write_reg(rpi_pkg::REG_PLANE_A, a);
    write_reg(rpi_pkg::REG_PLANE_B, b);
    write_reg(rpi_pkg::REG_PLANE_C, c);
    write_reg(rpi_pkg::REG_PLANE_D, d);
  endtask

  // One point transfer; the expectation is queued at the accepting edge
  task automatic send_point(rpi_pkg::in_item_t p, bit typed, rpi_pkg::out_item_t want);
    in_data  <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    hits_pending.insert(hits_pending.size(), typed ? want : hit_of(p));
    n_points++;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic add_row(rpi_pkg::coord_t x, rpi_pkg::coord_t y, rpi_pkg::coord_t z,
                         bit typed);
    stim_row_t r;
    r.pt    = '{point_x: x, point_y: y, point_z: z};
    r.typed = typed;
    r.want  = '0;
    // reset geometry: plane z = 0 seen from the origin, so every hit is the origin
    r.want.parallel = (z == '0);
    rows.insert(rows.size(), r);
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin
    rpi_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_hits++;
      if (hits_pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: %h", $time, out_data);
      end else begin
        want = hits_pending.pop_front();
        if (want.parallel) n_parallel++;
        if (want.saturated) n_sat++;
        if (out_data.hit_x !== want.hit_x || out_data.hit_y !== want.hit_y ||
            out_data.hit_z !== want.hit_z || out_data.parallel !== want.parallel ||
            out_data.saturated !== want.saturated) begin
          errors++;
          $display("%0t: mismatch expected x=%h y=%h z=%h par=%b sat=%b", $time,
                   want.hit_x, want.hit_y, want.hit_z, want.parallel, want.saturated);
          $display("%0t:          actual   x=%h y=%h z=%h par=%b sat=%b", $time,
                   out_data.hit_x, out_data.hit_y, out_data.hit_z,
                   out_data.parallel, out_data.saturated);
        end
      end
    end
  end

  // Result side back-pressure: random bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rpi_pkg::in_item_t p;
    errors     = 0;
    n_points   = 0;
    n_hits     = 0;
    n_parallel = 0;
    n_sat      = 0;
    idle_count = 0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    geom       = '{center_x: '0, center_y: '0, center_z: '0, plane_a: '0,
                   plane_b: '0, plane_c: 32'h0001_0000, plane_d: '0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes under the reset geometry, point at the centre
    add_row(32'h0, 32'h0, 32'h0, 1'b1);
    add_row(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1'b1);
    add_row(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 1'b1);
    add_row(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 1'b1);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
    add_row(32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 1'b1);
    foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].want);

    // Directed: camera above the plane, rays near parallel saturate, rays behind
    write_all('0, '0, 32'h0001_0000, '0, '0, 32'h0001_0000, '0);
    rows.delete();
    add_row(32'h7fff_ffff, 32'h8000_0000, 32'h0000_ffff, 1'b0);
    add_row(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0001, 1'b0);
    add_row(32'h0003_0000, 32'hfffd_0000, 32'h0000_8000, 1'b0);
    add_row(32'h0003_0000, 32'h0005_0000, 32'h0002_0000, 1'b0);
    add_row(32'h0000_0001, 32'h0000_0001, 32'h0001_0000, 1'b0);
    add_row(32'h0000_5555, 32'hffff_aaab, 32'h0000_0003, 1'b0);
    add_row(32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff, 1'b0);
    foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].want);

    // Random phases, each under its own geometry
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        1: write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        2: write_all(rand_coord(), rand_coord(), rand_coord(), '0, '0, '0, rand_coord());
        default: write_all(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord());
      endcase
      if (ph == 3) hold_req = 1'b1;
      if (ph == PHASES - 1) quiet = 1'b1;
      for (int k = 0; k < PER_PHASE; k++) begin
        p.point_x = rand_coord();
        p.point_y = rand_coord();
        p.point_z = rand_coord();
        // now and then aim straight at the centre
        if ($urandom_range(0, 31) == 0)
          p = '{point_x: geom.center_x, point_y: geom.center_y, point_z: geom.center_z};
        send_point(p, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (hits_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d points sent, %0d hits checked (%0d parallel, %0d saturated)",
             n_points, n_hits, n_parallel, n_sat);
    $display("%0d geometries incl. extreme and zero-normal planes, %0d errors",
             PHASES + 2, errors);
    if (errors == 0 && hits_pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
